/* sv/pump_boiler_hysteresis_switch_assert.svh */
// assertion macros shared by the checker of the hysteresis switch
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef PUMP_BOILER_HYSTERESIS_SWITCH_ASSERT_SVH
`define PUMP_BOILER_HYSTERESIS_SWITCH_ASSERT_SVH

// same-cycle implication, off during reset
`define HBS_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hysteresis switch check failed");

// next-cycle implication, off during reset
`define HBS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hysteresis switch check failed");

// next-cycle implication that also runs through reset
`define HBS_ASSERT_ALWAYS_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("hysteresis switch check failed");

`endif

/* sv/hbs_pkg.sv */
// types and constants of the pump and boiler hysteresis switch
// no dependencies
package hbs_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SEED = 2'd1,
        OP_ACK  = 2'd2
    } t_op;

    // configuration register indexes
    localparam logic [2:0] CFG_ALWAYS_ON  = 3'd0;
    localparam logic [2:0] CFG_PUMP_ON    = 3'd1;
    localparam logic [2:0] CFG_PUMP_HYST  = 3'd2;
    localparam logic [2:0] CFG_FIRE_OFF   = 3'd3;
    localparam logic [2:0] CFG_FIRE_ON    = 3'd4;
    localparam logic [2:0] CFG_OFF_MAX    = 3'd5;
    localparam logic [2:0] CFG_ON_MIN     = 3'd6;

    localparam int TEMP_W  = 12;
    localparam int HYST_W  = 8;
    localparam int SUM_OUT_W = 16;

    // reset values of the registers
    localparam int ALWAYS_ON_RST = 1120;
    localparam int PUMP_ON_RST   = 128;
    localparam int PUMP_HYST_RST = 16;
    localparam int FIRE_OFF_RST  = 48;
    localparam int FIRE_ON_RST   = 96;
    localparam int OFF_MAX_RST   = 1072;
    localparam int ON_MIN_RST    = 800;

    // window cell control
    typedef struct packed {
        logic shift;
        logic seed;
    } t_cell_ctl;

    // one result transaction
    typedef struct packed {
        logic                 pump_on;
        logic                 fire_on;
        logic                 boiler_cut;
        logic                 alarm_pulse;
        logic [SUM_OUT_W-1:0] window_sum;
    } t_result;

endpackage

/* sv/hbs_cell.sv */
// one window cell: holds a single flow-return delta
// depends on hbs_pkg
module hbs_cell
    import hbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [TEMP_W-1:0] i_seed_delta,
    input  logic [TEMP_W-1:0] i_prev,
    output logic [TEMP_W-1:0] o_entry
);

    logic [TEMP_W-1:0] r_entry;

    // seed loads the current delta, shift takes the neighbor's entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_ctl.seed) begin
            r_entry <= i_seed_delta;
        end else if (i_ctl.shift) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;

endmodule

/* sv/hbs_window.sv */
// delta window as a chain of cells with a running sum
// depends on hbs_pkg and hbs_cell
module hbs_window
    import hbs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int SUM_W = TEMP_W + $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [TEMP_W-1:0] i_delta,
    output logic [SUM_W-1:0]  o_sum_next
);

    logic [TEMP_W-1:0] w_entry [DEPTH];
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;

    // newest delta enters the first cell, oldest falls off the last
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        hbs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_seed_delta (i_delta),
            .i_prev       ((g == 0) ? i_delta : w_entry[(g == 0) ? 0 : g - 1]),
            .o_entry      (w_entry[g])
        );
    end

    // running sum follows the chain
    always_comb begin
        priority if (i_ctl.seed) begin
            n_sum = SUM_W'(i_delta) * SUM_W'(DEPTH);
        end else if (i_ctl.shift) begin
            n_sum = r_sum - SUM_W'(w_entry[DEPTH-1]) + SUM_W'(i_delta);
        end else begin
            n_sum = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum_next = n_sum;

endmodule

/* sv/hbs_skid.sv */
// output register with a skid stage for result transactions
// depends on hbs_pkg
module hbs_skid
    import hbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_take;

    assign w_take = i_valid && !r_skid_valid;

    // control: skid fills only when the output is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_take;
            end
        end else if (w_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (w_take) begin
            r_skid <= i_data;
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* sv/pump_boiler_hysteresis_switch.sv */
// top level of the pump and boiler hysteresis switch
// depends on hbs_pkg, hbs_window, hbs_skid
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  input    | i_in_valid / o_in_stall    | op, four temperatures, minute_mark
//  result   | o_out_valid / i_out_stall  | flags, relay levels, alarm, sum
//  config   | i_cfg_wr_en                | i_cfg_addr, i_cfg_wdata
//
// one transaction per cycle while o_in_stall is low; the result is registered
// in the output stage, or in the skid stage while the result side holds it
// the window shifts one cell per minute tick, a seed loads all cells at once
// synchronous active-low reset sets the pump flag, clears the fire and cut flags, window, sum and the output stages
// with the result held, one more transaction lands in the skid stage, then
// o_in_stall rises until the result side takes again
module pump_boiler_hysteresis_switch
    import hbs_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_op,
    input  logic signed [TEMP_W-1:0] i_source_temp,
    input  logic signed [TEMP_W-1:0] i_drinkwater_temp,
    input  logic signed [TEMP_W-1:0] i_flow_temp,
    input  logic signed [TEMP_W-1:0] i_return_temp,
    input  logic                     i_minute_mark,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_pump_on,
    output logic                     o_fire_on,
    output logic                     o_boiler_cut,
    output logic                     o_pump_relay_level,
    output logic                     o_boiler_relay_level,
    output logic                     o_alarm_pulse,
    output logic [SUM_OUT_W-1:0]     o_window_sum,
    input  logic                     i_cfg_wr_en,
    input  logic [2:0]               i_cfg_addr,
    input  logic [TEMP_W-1:0]        i_cfg_wdata
);

    localparam int SUM_W = TEMP_W + $clog2(WINDOW_DEPTH);
    localparam int CMP_W = SUM_W + 1;
    localparam int EXT_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W + 1;
    localparam logic signed [CMP_W-1:0] OFF_TH_RST = CMP_W'(FIRE_OFF_RST * WINDOW_DEPTH);
    localparam logic signed [CMP_W-1:0] ON_TH_RST  = CMP_W'(FIRE_ON_RST * WINDOW_DEPTH);

    // configuration registers, fire thresholds kept scaled by the depth
    logic signed [TEMP_W-1:0] r_always_on;
    logic signed [TEMP_W-1:0] r_pump_on;
    logic [HYST_W-1:0]        r_hyst;
    logic signed [CMP_W-1:0]  r_off_th;
    logic signed [CMP_W-1:0]  r_on_th;
    logic signed [TEMP_W-1:0] r_off_max;
    logic signed [TEMP_W-1:0] r_on_min;

    logic r_pump;
    logic r_fire;
    logic r_cut;
    logic n_pump;
    logic n_fire;
    logic n_cut;
    logic w_alarm;

    logic                     w_accept;
    t_op                      w_op;
    t_cell_ctl                w_cell_ctl;
    logic signed [TEMP_W:0]   w_flow_diff;
    logic [TEMP_W-1:0]        w_delta;
    logic [SUM_W-1:0]         w_sum_next;
    logic signed [CMP_W-1:0]  w_area;
    logic signed [CMP_W-1:0]  w_cfg_th;
    logic signed [TEMP_W+1:0] w_th;
    logic signed [TEMP_W+2:0] w_th_diff;
    logic signed [TEMP_W:0]   w_src_diff;
    logic [EXT_W-1:0]         w_sum_ext;
    t_result                  w_result;
    t_result                  w_out;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_op     = t_op'(i_op);

    // scaled threshold from the written value
    assign w_cfg_th = $signed(CMP_W'($signed(i_cfg_wdata))) * $signed(CMP_W'(WINDOW_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_always_on <= TEMP_W'(ALWAYS_ON_RST);
            r_pump_on   <= TEMP_W'(PUMP_ON_RST);
            r_hyst      <= HYST_W'(PUMP_HYST_RST);
            r_off_th    <= OFF_TH_RST;
            r_on_th     <= ON_TH_RST;
            r_off_max   <= TEMP_W'(OFF_MAX_RST);
            r_on_min    <= TEMP_W'(ON_MIN_RST);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_ALWAYS_ON: r_always_on <= i_cfg_wdata;
                CFG_PUMP_ON:   r_pump_on   <= i_cfg_wdata;
                CFG_PUMP_HYST: r_hyst      <= i_cfg_wdata[HYST_W-1:0];
                CFG_FIRE_OFF:  r_off_th    <= w_cfg_th;
                CFG_FIRE_ON:   r_on_th     <= w_cfg_th;
                CFG_OFF_MAX:   r_off_max   <= i_cfg_wdata;
                CFG_ON_MIN:    r_on_min    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // flow minus return, clamped at zero
    assign w_flow_diff = (TEMP_W + 1)'(i_flow_temp) - (TEMP_W + 1)'(i_return_temp);
    assign w_delta     = w_flow_diff[TEMP_W] ? '0 : w_flow_diff[TEMP_W-1:0];

    // window control
    assign w_cell_ctl.seed  = w_accept && (w_op == OP_SEED);
    assign w_cell_ctl.shift = w_accept && (w_op == OP_TICK) && i_minute_mark;

    hbs_window #(
        .DEPTH (WINDOW_DEPTH),
        .SUM_W (SUM_W)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_cell_ctl),
        .i_delta    (w_delta),
        .o_sum_next (w_sum_next)
    );

    // pump comparisons
    assign w_th       = (TEMP_W + 2)'(i_source_temp) + $signed({6'b0, r_hyst});
    assign w_th_diff  = (TEMP_W + 3)'(w_th) - (TEMP_W + 3)'(i_drinkwater_temp);
    assign w_src_diff = (TEMP_W + 1)'(i_source_temp) - (TEMP_W + 1)'(i_drinkwater_temp);
    assign w_area     = $signed({1'b0, w_sum_next});

    // next flags
    always_comb begin
        n_pump  = r_pump;
        n_fire  = r_fire;
        n_cut   = r_cut;
        w_alarm = 1'b0;
        unique case (w_op)
            OP_TICK: begin
                if (r_pump) begin
                    if (w_th_diff < (TEMP_W + 3)'(r_pump_on) &&
                        w_th < (TEMP_W + 2)'(r_always_on)) begin
                        n_pump = 1'b0;
                    end
                end else if (w_src_diff >= (TEMP_W + 1)'(r_pump_on) ||
                             i_source_temp >= r_always_on) begin
                    n_pump = 1'b1;
                end
                if (r_fire) begin
                    if (w_area < r_off_th && i_flow_temp <= r_off_max) begin
                        n_fire  = 1'b0;
                        n_cut   = 1'b1;
                        w_alarm = 1'b1;
                    end
                end else if (w_area >= r_on_th) begin
                    n_fire = 1'b1;
                end
                // power returns once the flow has cooled
                if (n_cut && i_flow_temp <= r_on_min) begin
                    n_cut = 1'b0;
                end
            end
            OP_ACK:  n_cut = 1'b0;
            OP_SEED: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump <= 1'b1;
            r_fire <= 1'b0;
            r_cut  <= 1'b0;
        end else if (w_accept) begin
            r_pump <= n_pump;
            r_fire <= n_fire;
            r_cut  <= n_cut;
        end
    end

    // result transaction, sum saturated to the field
    assign w_sum_ext = EXT_W'(w_sum_next);

    always_comb begin
        w_result.pump_on     = n_pump;
        w_result.fire_on     = n_fire;
        w_result.boiler_cut  = n_cut;
        w_result.alarm_pulse = w_alarm;
        w_result.window_sum  = (w_sum_ext > EXT_W'({SUM_OUT_W{1'b1}})) ?
                               {SUM_OUT_W{1'b1}} : w_sum_ext[SUM_OUT_W-1:0];
    end

    hbs_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .o_stall (o_in_stall),
        .i_data  (w_result),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_pump_on            = w_out.pump_on;
    assign o_fire_on            = w_out.fire_on;
    assign o_boiler_cut         = w_out.boiler_cut;
    assign o_pump_relay_level   = !w_out.pump_on;
    assign o_boiler_relay_level = !w_out.boiler_cut;
    assign o_alarm_pulse        = w_out.alarm_pulse;
    assign o_window_sum         = w_out.window_sum;

endmodule

/* sv/hbs_checker.sv */
// port-level checks of the hysteresis switch, bound to the top level
// depends on hbs_pkg and pump_boiler_hysteresis_switch_assert.svh
`include "pump_boiler_hysteresis_switch_assert.svh"

module hbs_checker
    import hbs_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic                     o_pump_on,
    input logic                     o_fire_on,
    input logic                     o_boiler_cut,
    input logic                     o_pump_relay_level,
    input logic                     o_boiler_relay_level,
    input logic                     o_alarm_pulse,
    input logic [SUM_OUT_W-1:0]     o_window_sum
);

    // relay pins are the inverted flags of the same transaction
    `HBS_ASSERT_IMPLY(a_relay_levels, o_out_valid,
        (o_pump_relay_level != o_pump_on) && (o_boiler_relay_level != o_boiler_cut))

    // an alarm only comes with the fire judged out
    `HBS_ASSERT_IMPLY(a_alarm_fire_out, o_out_valid && o_alarm_pulse, !o_fire_on)

    // a held result keeps its sum and flags
    `HBS_ASSERT_NEXT(a_result_held, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_window_sum) && $stable(o_fire_on) && $stable(o_pump_on))

    // nothing comes out or stalls right after reset
    `HBS_ASSERT_ALWAYS_NEXT(a_reset_empty, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind pump_boiler_hysteresis_switch hbs_checker u_hbs_checker (.*);
